@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/sfcc_pkg.sv @@
// ----------------------------------------------------------------------------
// Sensor frame CRC checker package
// Constants, result codes and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcc_pkg;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  HDR_BYTE0 = 8'h03;
    localparam logic [7:0]  HDR_BYTE1 = 8'h04;

    localparam int unsigned RESULT_BITS = 34;
    localparam int unsigned TDATA_BITS  = 40;

    typedef logic [2:0] byte_pos_t;

    localparam byte_pos_t POS_HDR0    = 3'd0;
    localparam byte_pos_t POS_HDR1    = 3'd1;
    localparam byte_pos_t POS_HUM_HI  = 3'd2;
    localparam byte_pos_t POS_HUM_LO  = 3'd3;
    localparam byte_pos_t POS_TEMP_HI = 3'd4;
    localparam byte_pos_t POS_TEMP_LO = 3'd5;
    localparam byte_pos_t POS_CRC_LO  = 3'd6;
    localparam byte_pos_t POS_CRC_HI  = 3'd7;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_HEADER = 2'd1,
        STATUS_BAD_CRC    = 2'd2
    } status_t;

    // One byte of the reflected CRC-16, least significant bit first.
    function automatic logic [15:0] crc_byte_update(input logic [15:0] crc,
                                                    input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sensor_frame_crc_checker_unit.sv @@
// ----------------------------------------------------------------------------
// Sensor frame CRC checker
// Checks the eight-byte sensor reply, its header and CRC, and extracts values.
// ----------------------------------------------------------------------------
// Bytes enter on the s_axis channel, one per transaction; tuser set marks the
// byte as the first of a new frame, and a partial frame is then dropped.
// Without the flag, the byte after the eighth starts a new frame.
// After the eighth byte one result leaves on the m_axis channel: the status
// (ok, bad header or bad CRC), the humidity and the temperature in two's
// complement, both zero on error. Other bytes give no result.
// A byte passes an input register and then the CRC, header and field logic
// into the result register, where the result of the eighth byte is held until
// it leaves. One byte is taken every cycle unless the eighth byte of a frame
// must wait for an earlier result; the CRC byte update is combinational. While
// a result waits for m_axis_tready, the next bytes still move on until a
// further result would be needed.
// Reset empties both registers and returns the frame position to the first
// byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_crc_checker_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] frame_start

    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [39:0] m_axis_tdata    // [1:0] status, [17:2] humidity,
                                             // [33:18] temperature, rest zero
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_start_reg;

    sfcc_pkg::byte_pos_t  byte_index_reg, byte_index_next;
    logic [15:0]          crc_acc_reg, crc_acc_next;
    logic                 header_bad_reg, header_bad_next;
    logic [15:0]          humidity_hold_reg, humidity_hold_next;
    logic [15:0]          temp_raw_hold_reg, temp_raw_hold_next;
    logic [7:0]           crc_low_byte_reg, crc_low_byte_next;

    logic                 out_valid_reg;
    sfcc_pkg::status_t    status_reg, status_next;
    logic [15:0]          humidity_reg, humidity_next;
    logic [15:0]          temperature_reg, temperature_next;

    sfcc_pkg::byte_pos_t  pos;
    logic                 produces;
    logic                 fire;
    logic [15:0]          crc_base;
    logic [15:0]          rx_crc;
    logic [14:0]          magnitude;
    logic                 s_accept;

    assign pos      = in_start_reg ? sfcc_pkg::POS_HDR0 : byte_index_reg;
    assign produces = (pos == sfcc_pkg::POS_CRC_HI);
    assign fire     = in_valid_reg && (!produces || !out_valid_reg || m_axis_tready);

    assign s_axis_tready = !in_valid_reg || fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign crc_base  = (pos == sfcc_pkg::POS_HDR0) ? sfcc_pkg::CRC_INIT : crc_acc_reg;
    assign rx_crc    = {in_byte_reg, crc_low_byte_reg};
    assign magnitude = temp_raw_hold_reg[14:0];

    always_comb
    begin
        byte_index_next    = pos + 3'd1;
        crc_acc_next       = crc_acc_reg;
        header_bad_next    = header_bad_reg;
        humidity_hold_next = humidity_hold_reg;
        temp_raw_hold_next = temp_raw_hold_reg;
        crc_low_byte_next  = crc_low_byte_reg;
        status_next        = sfcc_pkg::STATUS_OK;
        humidity_next      = 16'h0000;
        temperature_next   = 16'h0000;

        if (pos <= sfcc_pkg::POS_TEMP_LO)
        begin
            crc_acc_next = sfcc_pkg::crc_byte_update(crc_base, in_byte_reg);
        end

        unique case (pos)
            sfcc_pkg::POS_HDR0:
            begin
                header_bad_next    = (in_byte_reg != sfcc_pkg::HDR_BYTE0);
                humidity_hold_next = 16'h0000;
                temp_raw_hold_next = 16'h0000;
                crc_low_byte_next  = 8'h00;
            end
            sfcc_pkg::POS_HDR1:
            begin
                if (in_byte_reg != sfcc_pkg::HDR_BYTE1)
                begin
                    header_bad_next = 1'b1;
                end
            end
            sfcc_pkg::POS_HUM_HI:  humidity_hold_next[15:8] = in_byte_reg;
            sfcc_pkg::POS_HUM_LO:  humidity_hold_next[7:0]  = in_byte_reg;
            sfcc_pkg::POS_TEMP_HI: temp_raw_hold_next[15:8] = in_byte_reg;
            sfcc_pkg::POS_TEMP_LO: temp_raw_hold_next[7:0]  = in_byte_reg;
            sfcc_pkg::POS_CRC_LO:  crc_low_byte_next        = in_byte_reg;
            sfcc_pkg::POS_CRC_HI:
            begin
                priority if (header_bad_reg)
                begin
                    status_next = sfcc_pkg::STATUS_BAD_HEADER;
                end
                else if (rx_crc != crc_acc_reg)
                begin
                    status_next = sfcc_pkg::STATUS_BAD_CRC;
                end
                else
                begin
                    humidity_next = humidity_hold_reg;
                    if (temp_raw_hold_reg[15])
                    begin
                        temperature_next = 16'h0000 - {1'b0, magnitude};
                    end
                    else
                    begin
                        temperature_next = {1'b0, magnitude};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            byte_index_reg    <= sfcc_pkg::POS_HDR0;
            crc_acc_reg       <= sfcc_pkg::CRC_INIT;
            header_bad_reg    <= 1'b0;
            humidity_hold_reg <= 16'h0000;
            temp_raw_hold_reg <= 16'h0000;
            crc_low_byte_reg  <= 8'h00;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (fire && produces)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                byte_index_reg    <= byte_index_next;
                crc_acc_reg       <= crc_acc_next;
                header_bad_reg    <= header_bad_next;
                humidity_hold_reg <= humidity_hold_next;
                temp_raw_hold_reg <= temp_raw_hold_next;
                crc_low_byte_reg  <= crc_low_byte_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
        if (fire && produces)
        begin
            status_reg      <= status_next;
            humidity_reg    <= humidity_next;
            temperature_reg <= temperature_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(sfcc_pkg::TDATA_BITS - sfcc_pkg::RESULT_BITS){1'b0}},
                            temperature_reg, humidity_reg, status_reg};

endmodule

`default_nettype wire

@@ hw/rtl/sfcc_checker.sv @@
// ----------------------------------------------------------------------------
// Sensor frame CRC checker assertions
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sfcc_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);

    logic s_accept;

    assign s_accept = s_axis_tvalid && s_axis_tready;

    // A stalled result must hold its value.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // Only the three defined status codes are ever reported.
    `ASSERT_IMPLIES(a_status_code, clk, rst_n, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)

    // An error result carries zero humidity and temperature.
    `ASSERT_IMPLIES(a_error_zero, clk, rst_n, m_axis_tvalid && (m_axis_tdata[1:0] != 2'd0), m_axis_tdata[33:2] == 32'h0)

    // The padding above the result fields stays clear.
    `ASSERT_IMPLIES(a_pad_zero, clk, rst_n, m_axis_tvalid || s_accept, m_axis_tdata[39:34] == 6'h00)

endmodule

bind sensor_frame_crc_checker_unit sfcc_checker u_sfcc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ test/sfcc_reply_checker.sv @@
// ----------------------------------------------------------------------------
// Sensor frame CRC checker: result checker
// Watches both stream channels of the frame checker. It works out the result
// that each frame of accepted bytes brings about and compares every result transaction
// field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------

package sfcc_tb_pkg;

    import sfcc_pkg::*;

    typedef struct packed {
        logic [15:0] temperature;
        logic [15:0] humidity;
        status_t     status;
    } reply_result_t;

    // The data bits are fed in one at a time, least significant first.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc,
                                               input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 0; k < 8; k++)
        begin
            fb = c[0] ^ data[k];
            c = c >> 1;
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

module sfcc_reply_checker
    import sfcc_pkg::*;
    import sfcc_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    output int          mismatch_count,
    output int          outstanding
);

    byte_pos_t     frame_pos;
    logic [15:0]   crc_run;
    logic          hdr_err;
    logic [15:0]   hum_acc;
    logic [15:0]   temp_acc;
    logic [7:0]    crc_lo;
    reply_result_t expected_replies[$];
    int            fail_tally = 0;
    int            pending = 0;

    assign mismatch_count = fail_tally;
    assign outstanding    = pending;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        fail_tally++;
    endtask

    task automatic absorb_reply_byte(input logic [7:0] b, input logic first);
        byte_pos_t     pos;
        reply_result_t r;
        logic [15:0]   mag;
        pos = first ? POS_HDR0 : frame_pos;
        if (pos == POS_HDR0)
        begin
            crc_run  = CRC_INIT;
            hdr_err  = 1'b0;
            hum_acc  = '0;
            temp_acc = '0;
            crc_lo   = '0;
        end
        if (pos <= POS_TEMP_LO)
        begin
            crc_run = crc16_step(crc_run, b);
        end
        case (pos)
            POS_HDR0:    hdr_err = hdr_err | (b != HDR_BYTE0);
            POS_HDR1:    hdr_err = hdr_err | (b != HDR_BYTE1);
            POS_HUM_HI:  hum_acc[15:8] = b;
            POS_HUM_LO:  hum_acc[7:0] = b;
            POS_TEMP_HI: temp_acc[15:8] = b;
            POS_TEMP_LO: temp_acc[7:0] = b;
            POS_CRC_LO:  crc_lo = b;
            default:
            begin
                r = '0;
                if (hdr_err)
                begin
                    r.status = STATUS_BAD_HEADER;
                end
                else if ({b, crc_lo} != crc_run)
                begin
                    r.status = STATUS_BAD_CRC;
                end
                else
                begin
                    // Sign and magnitude become two's complement; negative zero gives zero.
                    mag = {1'b0, temp_acc[14:0]};
                    r.status = STATUS_OK;
                    r.humidity = hum_acc;
                    r.temperature = temp_acc[15] ? (16'd0 - mag) : mag;
                end
                expected_replies.push_back(r);
            end
        endcase
        frame_pos = pos + 3'd1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_result_t want;
        reply_result_t got;
        if (!rst_n)
        begin
            frame_pos = POS_HDR0;
            crc_run   = CRC_INIT;
            hdr_err   = 1'b0;
            hum_acc   = '0;
            temp_acc  = '0;
            crc_lo    = '0;
            expected_replies.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_reply_byte(s_axis_tdata, s_axis_tuser);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[33:0];
                if (expected_replies.size() == 0)
                begin
                    report_mismatch("unexpected result transaction", {14'd0, got.status}, '0);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got.status != want.status)
                    begin
                        report_mismatch("status", {14'd0, got.status}, {14'd0, want.status});
                    end
                    if (got.humidity != want.humidity)
                    begin
                        report_mismatch("humidity", got.humidity, want.humidity);
                    end
                    if (got.temperature != want.temperature)
                    begin
                        report_mismatch("temperature", got.temperature, want.temperature);
                    end
                    if (m_axis_tdata[39:34] != '0)
                    begin
                        report_mismatch("tdata padding", {10'd0, m_axis_tdata[39:34]}, '0);
                    end
                end
            end
        end
        pending = expected_replies.size();
    end

endmodule

@@ test/sensor_frame_crc_checker_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Sensor frame CRC checker testbench
// Sends sensor reply frames byte by byte: a few hand-made frames first, then
// random good, corrupted, truncated and stray bytes, with random gaps on the
// input side and random back-pressure on the result side.
// ----------------------------------------------------------------------------

module sensor_frame_crc_checker_unit_tb;

    import sfcc_pkg::*;
    import sfcc_tb_pkg::*;

    localparam int RANDOM_BYTES = 750;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_EVERY  = 150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [39:0] m_axis_tdata;

    int   mismatch_count;
    int   outstanding;
    int   cycle_count = 0;
    int   bytes_sent = 0;
    logic burst = 1'b0;
    int   ready_left = 0;
    logic ready_level = 1'b1;

    always #5 clk = ~clk;

    sensor_frame_crc_checker_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sfcc_reply_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Long runs of readiness, short stalls, and now and then a long one.
    always @(negedge clk)
    begin : result_pressure
        int pick;
        if (ready_left == 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                ready_level = 1'b1;
                ready_left = $urandom_range(1, 20);
            end
            else if (pick < 95)
            begin
                ready_level = 1'b0;
                ready_left = $urandom_range(1, 3);
            end
            else
            begin
                ready_level = 1'b0;
                ready_left = $urandom_range(10, 40);
            end
        end
        ready_left = ready_left - 1;
        m_axis_tready <= ready_level;
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (burst || pick < 60)
        begin
            return 0;
        end
        else if (pick < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [15:0] pick_temp();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] make_frame(input logic [7:0] h0, input logic [7:0] h1,
                                               input logic [15:0] hum,
                                               input logic [15:0] temp_raw);
        logic [63:0] f;
        logic [15:0] crc;
        f[7:0]   = h0;
        f[15:8]  = h1;
        f[23:16] = hum[15:8];
        f[31:24] = hum[7:0];
        f[39:32] = temp_raw[15:8];
        f[47:40] = temp_raw[7:0];
        crc = CRC_INIT;
        for (int k = 0; k < 6; k++)
        begin
            crc = crc16_step(crc, f[8*k +: 8]);
        end
        f[55:48] = crc[7:0];
        f[63:56] = crc[15:8];
        return f;
    endfunction

    // Entered and left just after a falling edge; valid stays high between
    // back-to-back transactions.
    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= first;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [63:0] f, input int count, input logic first);
        for (int k = 0; k < count; k++)
        begin
            send_byte(f[8*k +: 8], (k == 0) ? first : 1'b0);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin : stimulus
        logic [63:0] f;
        logic        aligned;
        int          kind;
        int          n;
        int          random_start;
        int          last_drain;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        f = make_frame(HDR_BYTE0, HDR_BYTE1, 16'hFFFF, 16'hFFFF);
        send_frame(f, 8, 1'b1);
        // Follows on without the start flag; sign set with zero magnitude.
        f = make_frame(HDR_BYTE0, HDR_BYTE1, 16'h0000, 16'h8000);
        send_frame(f, 8, 1'b0);
        // A lone header byte, dropped by the restart that follows.
        send_byte(HDR_BYTE0, 1'b1);
        // Wrong header and wrong CRC together.
        send_frame({64{1'b1}}, 8, 1'b1);
        drain_results();

        aligned = 1'b1;
        random_start = bytes_sent;
        last_drain = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            burst = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 99);
            f = make_frame(HDR_BYTE0, HDR_BYTE1, 16'($urandom), pick_temp());
            if (kind < 60)
            begin
                send_frame(f, 8, aligned ? 1'($urandom) : 1'b1);
                aligned = 1'b1;
            end
            else if (kind < 70)
            begin
                f[48 + $urandom_range(0, 15)] ^= 1'b1;
                send_frame(f, 8, 1'b1);
                aligned = 1'b1;
            end
            else if (kind < 80)
            begin
                case ($urandom_range(0, 2))
                    0:       f = make_frame(8'($urandom), HDR_BYTE1, f[31:16], f[47:32]);
                    1:       f = make_frame(HDR_BYTE0, 8'($urandom), f[31:16], f[47:32]);
                    default: f = make_frame(8'($urandom), 8'($urandom), f[31:16], f[47:32]);
                endcase
                send_frame(f, 8, 1'b1);
                aligned = 1'b1;
            end
            else if (kind < 90)
            begin
                send_frame(f, $urandom_range(1, 7), 1'b1);
                aligned = 1'b0;
            end
            else
            begin
                n = $urandom_range(1, 10);
                repeat (n) send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
                aligned = 1'b0;
            end
            if (bytes_sent - last_drain >= DRAIN_EVERY)
            begin
                drain_results();
                last_drain = bytes_sent;
            end
        end
        burst = 1'b0;

        drain_results();
        repeat (10) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/sfcc_pkg.sv
hw/rtl/sensor_frame_crc_checker_unit.sv
hw/rtl/sfcc_checker.sv
test/sfcc_reply_checker.sv
test/sensor_frame_crc_checker_unit_tb.sv
